/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Request and status codes, sequencer states and the command bundle that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEQ_DEPTH  = 1024;
  localparam int DEQ_DATA_W = 32;
  localparam int DEQ_REQ_W  = 3;
  localparam int DEQ_CNT_W  = $clog2(DEQ_DEPTH + 1);

  typedef enum logic [DEQ_REQ_W-1:0] {
    REQ_NONE       = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_RESP = 2'd3
  } deq_state_t;

  // One-cycle strobes from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the incoming request
    logic exec;   // update pointers, write a pushed word, read a popped word
    logic read;   // keep the popped word, read the new front and back words
  } deq_cmd_t;

endpackage

/* rtl/deq_if.sv */
// ----------------------------------------------------------------------------
// deq_if: request and result channels of the double-ended queue
// Valid/ready channels; a request moves at an edge where both are high.
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [DEQ_REQ_W-1:0]         req_type;
  logic signed [DEQ_DATA_W-1:0] push_value;

  modport source(output valid, req_type, push_value, input ready);
  modport sink(input valid, req_type, push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; #(parameter int CNT_W = DEQ_CNT_W) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [DEQ_DATA_W-1:0] popped_value;
  logic signed [DEQ_DATA_W-1:0] front_value;
  logic signed [DEQ_DATA_W-1:0] back_value;
  logic [CNT_W-1:0]             entry_count;
  logic                         is_empty;

  modport source(output valid, status, popped_value, front_value, back_value,
                 entry_count, is_empty, input ready);
  modport sink(input valid, status, popped_value, front_value, back_value,
               entry_count, is_empty, output ready);
endinterface

/* rtl/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl: request sequencer
// Walks each request through execute, read and result phases.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_cmd_t cmd
);

  deq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_READ;
      S_READ: state_nxt = S_RESP;
      S_RESP: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_READ: cmd.read = 1'b1;
      S_RESP: out_valid = 1'b1;
      default: ;
    endcase
  end

  // Never take a new request while a result is still on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  // An accepted request always leads into the execute phase.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.exec)
    else $error("accepted request not executed");

endmodule

/* rtl/deq_dp.sv */
// ----------------------------------------------------------------------------
// deq_dp: queue datapath
// Circular word store with one write port and two registered read ports,
// plus the head pointer, the entry count and the result registers.
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  deq_cmd_t                     cmd,
  input  logic [DEQ_REQ_W-1:0]         req_type,
  input  logic signed [DEQ_DATA_W-1:0] push_value,
  output logic [1:0]                   status,
  output logic signed [DEQ_DATA_W-1:0] popped_value,
  output logic signed [DEQ_DATA_W-1:0] front_value,
  output logic signed [DEQ_DATA_W-1:0] back_value,
  output logic [CNT_W-1:0]             entry_count,
  output logic                         is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = CNT_W + 1;

  logic [DEQ_DATA_W-1:0] mem [DEPTH];

  logic [DEQ_REQ_W-1:0]  req_r;
  logic [DEQ_DATA_W-1:0] val_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  status_t               status_r;
  logic                  pop_ok_r;
  logic [DEQ_DATA_W-1:0] popped_r;
  logic [DEQ_DATA_W-1:0] rd_a_q, rd_b_q;

  logic                  is_push, is_pop, full, empty, push_ok, pop_ok;
  logic [AW-1:0]         head_inc, head_dec, tail_slot, back_slot;
  logic [SW-1:0]         tail_sum;
  logic                  we, re_a, re_b;
  logic [AW-1:0]         wa, ra_a;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return r[AW-1:0];
  endfunction

  assign is_push  = (req_r == REQ_PUSH_FRONT) || (req_r == REQ_PUSH_BACK);
  assign is_pop   = (req_r == REQ_POP_FRONT) || (req_r == REQ_POP_BACK);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign push_ok  = is_push && !full;
  assign pop_ok   = is_pop && !empty;

  assign head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign tail_sum  = SW'(head_r) + SW'(cnt_r);
  assign tail_slot = wrap(tail_sum);
  assign back_slot = wrap(tail_sum - SW'(1));

  assign we   = cmd.exec && push_ok;
  assign wa   = (req_r == REQ_PUSH_FRONT) ? head_dec : tail_slot;
  assign re_a = (cmd.exec && pop_ok) || cmd.read;
  assign ra_a = (cmd.exec && (req_r == REQ_POP_BACK)) ? back_slot : head_r;
  assign re_b = cmd.read;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= val_r;
    if (re_a) rd_a_q <= mem[ra_a];
    if (re_b) rd_b_q <= mem[back_slot];
  end

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (cmd.exec) begin
      priority if (req_r == REQ_CLEAR) begin
        head_nxt = '0;
        cnt_nxt  = '0;
      end else if (push_ok) begin
        if (req_r == REQ_PUSH_FRONT) head_nxt = head_dec;
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (pop_ok) begin
        if (req_r == REQ_POP_FRONT) head_nxt = head_inc;
        cnt_nxt = cnt_r - CNT_W'(1);
      end else begin
        // No-op, spare codes and refused requests leave the pointers alone.
        head_nxt = head_r;
        cnt_nxt  = cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= req_type;
      val_r <= push_value;
    end
    if (cmd.exec) begin
      pop_ok_r <= pop_ok;
      priority if (is_push && full) status_r <= ST_FULL;
      else if (is_pop && empty)     status_r <= ST_EMPTY;
      else                          status_r <= ST_OK;
    end
    if (cmd.read) popped_r <= pop_ok_r ? rd_a_q : '0;
  end

  assign status       = status_r;
  assign popped_value = popped_r;
  assign front_value  = empty ? '0 : rd_a_q;
  assign back_value   = empty ? '0 : rd_b_q;
  assign entry_count  = cnt_r;
  assign is_empty     = empty;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && push_ok) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("accepted push did not add an entry");

endmodule

/* rtl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue: double-ended queue of signed 32-bit words
// Top level: request sequencer plus circular-store datapath.
// ----------------------------------------------------------------------------
// Each request pushes a word at the front or back, pops a word from the
// front or back, clears the queue, or does nothing, and yields exactly one
// result carrying a status, the popped word, the front and back words after
// the request, the entry count and an empty flag. A pop on an empty queue
// reports an empty error and a push on a full queue reports a full error;
// neither changes anything. Clear only resets the head pointer and the
// count, so it takes one pass like any other request. A request is first
// accepted, then the pointers are updated and the store write or the
// popped-word read is done, then the new front and back words are read,
// and then the result is presented. The single sequencer walks one
// request at a time through the store, whose read data is registered.
// Results stay on offer until taken, and no new request is accepted until
// then. The store has DEPTH words and needs no clearing after reset, since
// only words written by a push are ever read. The result interface's entry
// count width must equal clog2(DEPTH + 1).
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  deq_req_if.sink      in_req,
  deq_rsp_if.source    out_rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  deq_cmd_t cmd;

  // Sequencer: owns both handshakes and strobes the datapath phases.
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  // Datapath: store, pointers and the result registers that the result
  // channel reads directly while a result is on offer.
  deq_dp #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .req_type     (in_req.req_type),
    .push_value   (in_req.push_value),
    .status       (out_rsp.status),
    .popped_value (out_rsp.popped_value),
    .front_value  (out_rsp.front_value),
    .back_value   (out_rsp.back_value),
    .entry_count  (out_rsp.entry_count),
    .is_empty     (out_rsp.is_empty)
  );

endmodule

/* sim/double_ended_queue_tb.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the double-ended queue
// Drives push, pop, clear and idle requests through the request channel and
// checks every result against a behavioral deque that runs in lockstep with
// each accepted request. The run covers empty and full errors, pointer
// wrap-around, and random traffic under several sender and receiver idle
// profiles.
// ----------------------------------------------------------------------------
module double_ended_queue_tb import deq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Request codes 6 and 7 are not part of the request enum; the block must
  // treat them like a no-op request.
  localparam logic [DEQ_REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [DEQ_REQ_W-1:0] REQ_SPARE_B = 3'd7;

  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

  // Cycles without any handshake on either channel before the run is
  // declared hung. The worst legal quiet stretch is a long run of random
  // idle cycles at 81 percent on one side, which stays far below this.
  localparam int QUIET_LIMIT = 4000;
  // Extra cycles after the last result.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [DEQ_REQ_W-1:0] kind;
    logic [31:0]          word;
  } deq_request_t;

  typedef struct {
    status_t              status;
    logic [31:0]          popped;
    logic [31:0]          front;
    logic [31:0]          back;
    logic [DEQ_CNT_W-1:0] level;
    logic                 empty;
  } deq_result_t;

  logic clk;
  logic rst_n;

  deq_req_if in_req ();
  deq_rsp_if out_rsp ();

  double_ended_queue #(
    .DEPTH (DEQ_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // Requests waiting to be offered, and the results the deque model says
  // the block still owes us, oldest first.
  deq_request_t request_q[$];
  deq_result_t  owed_results[$];

  // Shadow deque: the bench's own copy of the circular store and pointers.
  logic [31:0] word_mem [DEQ_DEPTH];
  int          head_ptr;
  int          fill_level;

  // Idle profile of the current phase, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;

  int  queued_count;
  int  accepted_count;
  int  checked_count;
  int  error_count;
  int  full_refusals;
  int  empty_refusals;
  int  peak_fill;
  int  quiet_cycles;
  logic req_taken;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Deque model. Applies one request to the shadow state and returns the
  // result the block must produce for it.
  // --------------------------------------------------------------------------
  function automatic deq_result_t apply_request(input logic [DEQ_REQ_W-1:0] kind,
                                                input logic [31:0] word);
    deq_result_t r;
    r.status = ST_OK;
    r.popped = '0;
    r.front  = '0;
    r.back   = '0;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill_level >= DEQ_DEPTH) begin
          // A push into a full queue is refused and leaves the state alone.
          r.status = ST_FULL;
          full_refusals++;
        end else if (kind == REQ_PUSH_FRONT) begin
          head_ptr = (head_ptr + DEQ_DEPTH - 1) % DEQ_DEPTH;
          word_mem[head_ptr] = word;
          fill_level++;
        end else begin
          word_mem[(head_ptr + fill_level) % DEQ_DEPTH] = word;
          fill_level++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
          empty_refusals++;
        end else if (kind == REQ_POP_FRONT) begin
          r.popped = word_mem[head_ptr];
          head_ptr = (head_ptr + 1) % DEQ_DEPTH;
          fill_level--;
        end else begin
          r.popped = word_mem[(head_ptr + fill_level - 1) % DEQ_DEPTH];
          fill_level--;
        end
      end
      REQ_CLEAR: begin
        // Clear only rewinds the pointers; stored words stay where they are.
        head_ptr   = 0;
        fill_level = 0;
      end
      default: begin
        // No-op and the two spare codes change nothing.
      end
    endcase
    if (fill_level != 0) begin
      r.front = word_mem[head_ptr];
      r.back  = word_mem[(head_ptr + fill_level - 1) % DEQ_DEPTH];
    end
    r.level = DEQ_CNT_W'(fill_level);
    r.empty = (fill_level == 0);
    if (fill_level > peak_fill) peak_fill = fill_level;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_REPORTS)
      $display("MISMATCH at result %0d, %s: got %h, expected %h",
               checked_count, field, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_request(input logic [DEQ_REQ_W-1:0] kind, input logic [31:0] word);
    deq_request_t item;
    item.kind = kind;
    item.word = word;
    request_q.insert(request_q.size(), item);
    queued_count++;
  endtask

  // Mostly uniform words, with the sign and all-ones/all-zeros corners mixed
  // in so that every bit is seen both ways and the extremes come up often.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 11))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DEQ_REQ_W-1:0] random_push();
    return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
  endfunction

  function automatic logic [DEQ_REQ_W-1:0] random_pop();
    return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
  endfunction

  // Random walk over the fill level. Each burst leans toward growing,
  // shrinking or holding steady, so the queue spends time near empty
  // (where pops get refused) and also away from it. Clear and the no-op
  // codes are sprinkled in as noise.
  task automatic gen_random_walk(input int n);
    int burst_left;
    int lean;
    int pick;
    logic [DEQ_REQ_W-1:0] kind;
    burst_left = 0;
    lean       = 50;
    repeat (n) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(4, 64);
        lean       = 20 + 30 * $urandom_range(0, 2);
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        kind = REQ_CLEAR;
      end else if (pick < 7) begin
        case ($urandom_range(0, 2))
          0:       kind = REQ_NONE;
          1:       kind = REQ_SPARE_A;
          default: kind = REQ_SPARE_B;
        endcase
      end else if ($urandom_range(0, 99) < lean) begin
        kind = random_push();
      end else begin
        kind = random_pop();
      end
      add_request(kind, random_word());
    end
  endtask

  // Fill the queue to the brim from both ends, bounce off the full limit a
  // few times, pop a stretch from both ends, then clear it while it still
  // holds words and pop past empty.
  task automatic gen_fill_and_drain();
    add_request(REQ_CLEAR, random_word());
    repeat (DEQ_DEPTH) add_request(random_push(), random_word());
    add_request(REQ_PUSH_FRONT, random_word());
    add_request(REQ_PUSH_BACK, random_word());
    add_request(REQ_POP_FRONT, random_word());
    add_request(REQ_PUSH_BACK, random_word());
    add_request(REQ_PUSH_FRONT, random_word());
    add_request(REQ_POP_BACK, random_word());
    add_request(REQ_PUSH_FRONT, random_word());
    add_request(REQ_PUSH_BACK, random_word());
    repeat (32) add_request(random_pop(), random_word());
    add_request(REQ_CLEAR, random_word());
    add_request(REQ_POP_FRONT, random_word());
    add_request(REQ_POP_BACK, random_word());
  endtask

  // Wait until the queued requests have all been taken and every result
  // they owe has come back.
  task automatic wait_drained();
    while (accepted_count != queued_count || owed_results.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Request driver and result-side ready. Both change on the falling edge so
  // the block sees them stable at the next rising edge. A request that is on
  // offer stays on offer, unchanged, until the block takes it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    deq_request_t nxt;
    if (!rst_n) begin
      in_req.valid  <= 1'b0;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (in_req.valid && !req_taken) begin
        // Still waiting on the block: hold the current request.
      end else if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = request_q[0];
        request_q.delete(0);
        in_req.valid      <= 1'b1;
        in_req.req_type   <= nxt.kind;
        in_req.push_value <= nxt.word;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and checker. On each rising edge an accepted request is run
  // through the deque model, and an accepted result is compared field by
  // field with the oldest owed result. The watchdog sits at the very end.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    deq_result_t want;
    if (!rst_n) begin
      req_taken    <= 1'b0;
      quiet_cycles = 0;
    end else begin
      req_taken <= in_req.valid && in_req.ready;
      quiet_cycles++;
      if (in_req.valid && in_req.ready) begin
        want = apply_request(in_req.req_type, in_req.push_value);
        owed_results.insert(owed_results.size(), want);
        accepted_count++;
        quiet_cycles = 0;
      end
      if (out_rsp.valid && out_rsp.ready) begin
        quiet_cycles = 0;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_rsp.status), 32'(ST_OK));
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (out_rsp.status !== want.status)
            report_mismatch("status", 32'(out_rsp.status), 32'(want.status));
          if (out_rsp.popped_value !== want.popped)
            report_mismatch("popped_value", out_rsp.popped_value, want.popped);
          if (out_rsp.front_value !== want.front)
            report_mismatch("front_value", out_rsp.front_value, want.front);
          if (out_rsp.back_value !== want.back)
            report_mismatch("back_value", out_rsp.back_value, want.back);
          if (out_rsp.entry_count !== want.level)
            report_mismatch("entry_count", 32'(out_rsp.entry_count), 32'(want.level));
          if (out_rsp.is_empty !== want.empty)
            report_mismatch("is_empty", 32'(out_rsp.is_empty), 32'(want.empty));
        end
        checked_count++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // Every input of the block is known from time zero.
    rst_n             = 1'b0;
    in_req.valid      = 1'b0;
    in_req.req_type   = REQ_NONE;
    in_req.push_value = '0;
    out_rsp.ready     = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    head_ptr          = 0;
    fill_level        = 0;
    queued_count      = 0;
    accepted_count    = 0;
    checked_count     = 0;
    error_count       = 0;
    full_refusals     = 0;
    empty_refusals    = 0;
    peak_fill         = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening, no idling. Pops on an empty queue, the no-op and
    // spare codes, pushes of the word extremes from both ends (the first
    // front push wraps the head pointer below zero), pops from both ends
    // down to one word and then to empty, and clear with words still held.
    add_request(REQ_POP_FRONT, 32'h1234_5678);
    add_request(REQ_POP_BACK, WORD_MAX);
    add_request(REQ_NONE, WORD_MIN);
    add_request(REQ_SPARE_A, 32'hFFFF_FFFF);
    add_request(REQ_SPARE_B, 32'h0000_0000);
    add_request(REQ_PUSH_FRONT, WORD_MIN);
    add_request(REQ_PUSH_BACK, WORD_MAX);
    add_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    add_request(REQ_PUSH_BACK, 32'h0000_0000);
    add_request(REQ_PUSH_FRONT, 32'h0000_0001);
    add_request(REQ_PUSH_BACK, 32'hAAAA_AAAA);
    add_request(REQ_POP_FRONT, 32'h5555_5555);
    add_request(REQ_POP_BACK, 32'h5555_5555);
    add_request(REQ_NONE, 32'hDEAD_BEEF);
    add_request(REQ_POP_BACK, 32'h0);
    add_request(REQ_POP_FRONT, 32'h0);
    add_request(REQ_POP_FRONT, 32'h0);
    add_request(REQ_POP_BACK, 32'h0);
    add_request(REQ_POP_FRONT, 32'h0);
    add_request(REQ_PUSH_BACK, 32'h0F0F_0F0F);
    add_request(REQ_PUSH_FRONT, 32'hF0F0_F0F0);
    add_request(REQ_CLEAR, 32'h0);
    add_request(REQ_POP_BACK, 32'h0);
    add_request(REQ_PUSH_BACK, 32'h5555_5555);
    add_request(REQ_CLEAR, 32'hFFFF_FFFF);
    wait_drained();

    // Full-depth pass and a random walk, still at full rate on both sides.
    gen_fill_and_drain();
    gen_random_walk(30);
    wait_drained();

    // Sender mostly idle: the block sits waiting between requests.
    send_idle_pct  = 81;
    recv_stall_pct = 0;
    gen_random_walk(30);
    wait_drained();

    // Receiver mostly stalling: results pile up on the output and the
    // block must hold off the next request until each one is taken.
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    gen_random_walk(30);
    wait_drained();

    // Light idling on both sides, so gaps land at every point of a request.
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    gen_random_walk(30);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests and checked %0d results, deepest fill %0d of %0d words.",
             accepted_count, checked_count, peak_fill, DEQ_DEPTH);
    $display("Saw %0d pushes refused on a full queue and %0d pops refused on an empty one.",
             full_refusals, empty_refusals);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
